>>> sv/gcode_line_framer_macros.svh
// Assertion macros used by the framer back end.
// Each macro expects signals named clk and rst_n in the enclosing module.
`ifndef GCODE_LINE_FRAMER_MACROS_SVH
`define GCODE_LINE_FRAMER_MACROS_SVH

// A condition that must hold at every clock edge out of reset.
`define GCLF_ASSERT_ALWAYS(label, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error("gclf: invariant violated");

// A condition that must hold in the same cycle as a trigger.
`define GCLF_ASSERT_IMPLY(label, trig, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |-> (cond)) \
        else $error("gclf: implication violated");

// A condition that must hold in the cycle after a trigger.
`define GCLF_ASSERT_NEXT(label, trig, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (cond)) \
        else $error("gclf: next-cycle check violated");

`endif

>>> sv/gclf_pkg.sv
package gclf_pkg;

    // Byte codes seen on the serial stream.
    localparam logic [7:0] BYTE_STATUS  = 8'h3F;
    localparam logic [7:0] BYTE_HOLD    = 8'h21;
    localparam logic [7:0] BYTE_RESUME  = 8'h7E;
    localparam logic [7:0] BYTE_RESET   = 8'h18;
    localparam logic [7:0] BYTE_PERCENT = 8'h25;
    localparam logic [7:0] BYTE_STAR    = 8'h2A;
    localparam logic [7:0] BYTE_SEMI    = 8'h3B;
    localparam logic [7:0] BYTE_OPEN    = 8'h28;
    localparam logic [7:0] BYTE_CLOSE   = 8'h29;
    localparam logic [7:0] BYTE_CR      = 8'h0D;
    localparam logic [7:0] BYTE_LF      = 8'h0A;
    localparam logic [7:0] BYTE_SPACE   = 8'h20;
    localparam logic [7:0] BYTE_TAB     = 8'h09;
    localparam logic [7:0] BYTE_LOWER_A = 8'h61;
    localparam logic [7:0] BYTE_LOWER_Z = 8'h7A;
    localparam logic [7:0] CASE_OFFSET  = 8'h20;

    localparam int          LIMIT_W         = 9;
    localparam logic [8:0]  LINE_LIMIT_MAX  = 9'd256;

    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    typedef enum logic [1:0] {
        KIND_CHAR     = 2'd0,
        KIND_REALTIME = 2'd1,
        KIND_DONE     = 2'd2,
        KIND_ERROR    = 2'd3
    } gclf_kind_t;

    typedef enum logic [1:0] {
        RT_STATUS = 2'd0,
        RT_HOLD   = 2'd1,
        RT_RESUME = 2'd2,
        RT_RESET  = 2'd3
    } gclf_rt_t;

    typedef enum logic {
        ERR_COMMENT  = 1'b0,
        ERR_OVERFLOW = 1'b1
    } gclf_err_t;

    // Byte classes decided by the front end.
    typedef enum logic [2:0] {
        CLS_REALTIME = 3'd0,
        CLS_EOL      = 3'd1,
        CLS_PERCENT  = 3'd2,
        CLS_REST     = 3'd3,
        CLS_OPEN     = 3'd4,
        CLS_CLOSE    = 3'd5,
        CLS_SPACE    = 3'd6,
        CLS_CHAR     = 3'd7
    } gclf_class_t;

    typedef struct packed {
        gclf_class_t cls;
        logic [7:0]  ch;   // uppercased byte for ordinary characters
        gclf_rt_t    rt;   // command code for realtime bytes
    } gclf_entry_t;

endpackage

>>> sv/gclf_front.sv
module gclf_front
    import gclf_pkg::*;
(
    input  logic [7:0]  byte_in,
    output gclf_entry_t entry
);

    always_comb
    begin
        entry.cls = CLS_CHAR;
        entry.ch  = byte_in;
        entry.rt  = RT_STATUS;
        if ((byte_in >= BYTE_LOWER_A) && (byte_in <= BYTE_LOWER_Z))
        begin
            entry.ch = byte_in - CASE_OFFSET;
        end
        priority if (byte_in == BYTE_STATUS)
        begin
            entry.cls = CLS_REALTIME;
            entry.rt  = RT_STATUS;
        end
        else if (byte_in == BYTE_HOLD)
        begin
            entry.cls = CLS_REALTIME;
            entry.rt  = RT_HOLD;
        end
        else if (byte_in == BYTE_RESUME)
        begin
            entry.cls = CLS_REALTIME;
            entry.rt  = RT_RESUME;
        end
        else if (byte_in == BYTE_RESET)
        begin
            entry.cls = CLS_REALTIME;
            entry.rt  = RT_RESET;
        end
        else if ((byte_in == BYTE_CR) || (byte_in == BYTE_LF))
        begin
            entry.cls = CLS_EOL;
        end
        else if (byte_in == BYTE_PERCENT)
        begin
            entry.cls = CLS_PERCENT;
        end
        else if ((byte_in == BYTE_STAR) || (byte_in == BYTE_SEMI))
        begin
            entry.cls = CLS_REST;
        end
        else if (byte_in == BYTE_OPEN)
        begin
            entry.cls = CLS_OPEN;
        end
        else if (byte_in == BYTE_CLOSE)
        begin
            entry.cls = CLS_CLOSE;
        end
        else if ((byte_in == BYTE_SPACE) ||
                 ((byte_in >= BYTE_TAB) && (byte_in <= BYTE_CR)))
        begin
            entry.cls = CLS_SPACE;
        end
        else
        begin
            entry.cls = CLS_CHAR;
        end
    end

endmodule

>>> sv/gclf_queue.sv
module gclf_queue
    import gclf_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push_valid,
    output logic        push_ready,
    input  gclf_entry_t push_entry,
    output logic        pop_valid,
    input  logic        pop_ready,
    output gclf_entry_t pop_entry
);

    gclf_entry_t              mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0]        wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0]        rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0]        count_reg, count_next;
    logic                     push, pop;

    assign push_ready = (count_reg != QCNT_W'(QUEUE_DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign push       = push_valid && push_ready;
    assign pop        = pop_valid && pop_ready;
    assign pop_entry  = mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= push_entry;
        end
    end

endmodule

>>> sv/gclf_back.sv
`include "gcode_line_framer_macros.svh"

module gclf_back
    import gclf_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_wen,
    input  logic [LIMIT_W-1:0]  cfg_wdata,
    input  logic                pop_valid,
    output logic                pop_ready,
    input  gclf_entry_t         pop_entry,
    output logic                out_valid,
    input  logic                out_ready,
    output gclf_kind_t          out_kind,
    output logic [7:0]          out_char,
    output gclf_rt_t            out_rt,
    output logic                out_empty,
    output gclf_err_t           out_err
);

    logic [LIMIT_W-1:0] limit_reg;
    logic [LIMIT_W-1:0] eff_limit;
    logic [LIMIT_W-1:0] raw_count_reg, raw_count_next;
    logic               in_comment_reg, in_comment_next;
    logic               rest_ignored_reg, rest_ignored_next;
    logic               any_kept_reg, any_kept_next;
    logic               out_valid_reg, out_valid_next;
    gclf_kind_t         kind_reg, kind_next;
    logic [7:0]         char_reg, char_next;
    gclf_rt_t           rt_reg, rt_next;
    logic               empty_reg, empty_next;
    gclf_err_t          err_reg, err_next;
    logic               pop, produce;

    assign pop_ready = !out_valid_reg || out_ready;
    assign pop       = pop_valid && pop_ready;
    assign eff_limit = ((limit_reg == '0) || (limit_reg > LINE_LIMIT_MAX)) ?
                       LINE_LIMIT_MAX : limit_reg;

    always_comb
    begin
        raw_count_next    = raw_count_reg;
        in_comment_next   = in_comment_reg;
        rest_ignored_next = rest_ignored_reg;
        any_kept_next     = any_kept_reg;
        produce           = 1'b0;
        kind_next         = KIND_CHAR;
        char_next         = 8'h00;
        rt_next           = RT_STATUS;
        empty_next        = 1'b0;
        err_next          = ERR_COMMENT;
        if (pop)
        begin
            unique case (pop_entry.cls)
                CLS_REALTIME:
                begin
                    produce   = 1'b1;
                    kind_next = KIND_REALTIME;
                    rt_next   = pop_entry.rt;
                end
                CLS_EOL:
                begin
                    if (raw_count_reg != '0)
                    begin
                        produce           = 1'b1;
                        raw_count_next    = '0;
                        in_comment_next   = 1'b0;
                        rest_ignored_next = 1'b0;
                        any_kept_next     = 1'b0;
                        if (in_comment_reg)
                        begin
                            kind_next = KIND_ERROR;
                            err_next  = ERR_COMMENT;
                        end
                        else
                        begin
                            kind_next  = KIND_DONE;
                            empty_next = !any_kept_reg;
                        end
                    end
                end
                default:
                begin
                    if (raw_count_reg >= eff_limit)
                    begin
                        // Overflow drops the byte and starts a fresh line.
                        produce           = 1'b1;
                        kind_next         = KIND_ERROR;
                        err_next          = ERR_OVERFLOW;
                        raw_count_next    = '0;
                        in_comment_next   = 1'b0;
                        rest_ignored_next = 1'b0;
                        any_kept_next     = 1'b0;
                    end
                    else
                    begin
                        raw_count_next = raw_count_reg + 1'b1;
                        if (!rest_ignored_reg)
                        begin
                            priority case (pop_entry.cls)
                                CLS_PERCENT: ;
                                CLS_REST:    rest_ignored_next = 1'b1;
                                CLS_OPEN:    in_comment_next   = 1'b1;
                                CLS_CLOSE:   in_comment_next   = 1'b0;
                                CLS_CHAR:
                                begin
                                    if (!in_comment_reg)
                                    begin
                                        produce       = 1'b1;
                                        any_kept_next = 1'b1;
                                        kind_next     = KIND_CHAR;
                                        char_next     = pop_entry.ch;
                                    end
                                end
                                default: ;
                            endcase
                        end
                    end
                end
            endcase
        end
        if (pop)
        begin
            out_valid_next = produce;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            limit_reg        <= LINE_LIMIT_MAX;
            raw_count_reg    <= '0;
            in_comment_reg   <= 1'b0;
            rest_ignored_reg <= 1'b0;
            any_kept_reg     <= 1'b0;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            if (cfg_wen)
            begin
                limit_reg <= cfg_wdata;
            end
            raw_count_reg    <= raw_count_next;
            in_comment_reg   <= in_comment_next;
            rest_ignored_reg <= rest_ignored_next;
            any_kept_reg     <= any_kept_next;
            out_valid_reg    <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop && produce)
        begin
            kind_reg  <= kind_next;
            char_reg  <= char_next;
            rt_reg    <= rt_next;
            empty_reg <= empty_next;
            err_reg   <= err_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_kind  = kind_reg;
    assign out_char  = char_reg;
    assign out_rt    = rt_reg;
    assign out_empty = empty_reg;
    assign out_err   = err_reg;

    `GCLF_ASSERT_ALWAYS(a_raw_in_range, raw_count_reg <= LINE_LIMIT_MAX)
    `GCLF_ASSERT_IMPLY(a_pop_only_when_free, pop, !out_valid_reg || out_ready)
    `GCLF_ASSERT_IMPLY(a_char_fields_clean, out_valid_reg && (kind_reg == KIND_CHAR),
                       (rt_reg == RT_STATUS) && !empty_reg && (err_reg == ERR_COMMENT))
    `GCLF_ASSERT_NEXT(a_eol_clears_line,
                      pop && (pop_entry.cls == CLS_EOL),
                      (raw_count_reg == '0) && !in_comment_reg && !any_kept_reg)

endmodule

>>> sv/gcode_line_framer.sv
// Channel  | Direction | Fields (lowest bit first)
// ---------+-----------+------------------------------------------------------
// s_axis   | in        | tdata: byte_in[7:0]
// m_axis   | out       | tuser: kind[1:0]; tdata: char_out[7:0],
//          |           |   realtime_cmd[9:8], line_empty[10], error_code[11]
// cfg      | in        | cfg_wdata: max_line_length[8:0], written when cfg_wen
//
// An item can be accepted every cycle unless the queue is full. It is classified on the
// way in and queued, and the back end later registers its result, if any, for output.
// A four-entry queue parts the halves: a stalled output fills it, and only a full queue
// drops s_tready. The back end takes one queued item per cycle while its output is free.
// Reset is asynchronous and active low; it empties the queue, clears the line state and
// returns max_line_length to 256.
module gcode_line_framer
    import gclf_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         cfg_wen,
    input  logic [8:0]   cfg_wdata,       // max_line_length[8:0]
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [7:0]   s_tdata,         // byte_in[7:0]
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [15:0]  m_tdata,         // char_out[7:0], realtime_cmd[9:8],
                                          // line_empty[10], error_code[11]
    output logic [1:0]   m_tuser          // kind[1:0]
);

    gclf_entry_t  front_entry;
    gclf_entry_t  queue_entry;
    logic         queue_valid;
    logic         queue_ready;
    gclf_kind_t   res_kind;
    logic [7:0]   res_char;
    gclf_rt_t     res_rt;
    logic         res_empty;
    gclf_err_t    res_err;

    // The front end sorts each byte into a class and uppercases letters, so the
    // back end only has to track comment, ignore, count and kept-character state.
    gclf_front u_front
    (
        .byte_in (s_tdata),
        .entry   (front_entry)
    );

    gclf_queue u_queue
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (s_tvalid),
        .push_ready (s_tready),
        .push_entry (front_entry),
        .pop_valid  (queue_valid),
        .pop_ready  (queue_ready),
        .pop_entry  (queue_entry)
    );

    // The back end owns the length limit and the per-line state, and holds each
    // result in an output register until the sink takes it.
    gclf_back u_back
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wen   (cfg_wen),
        .cfg_wdata (cfg_wdata),
        .pop_valid (queue_valid),
        .pop_ready (queue_ready),
        .pop_entry (queue_entry),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_kind  (res_kind),
        .out_char  (res_char),
        .out_rt    (res_rt),
        .out_empty (res_empty),
        .out_err   (res_err)
    );

    assign m_tuser = res_kind;
    assign m_tdata = {4'b0000, res_err, res_empty, res_rt, res_char};

endmodule
